// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/uks_pkg.sv -----
`default_nettype none
package uks_pkg;

  localparam int OPCODE_W      = 2;
  localparam int STATUS_W      = 2;
  localparam int KEY_W         = 32;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 5;
  localparam int DEPTH_DEFAULT = 16;

  // Request kinds.
  localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PEEK = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage
`default_nettype wire

// ----- rtl/core/uks_cell.sv -----
`default_nettype none
// One stack slot. Cell 0 is the top of stack; a push moves every entry one
// cell deeper and a pop moves every entry one cell up.
module uks_cell #(
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  wire logic                      clk,
  input  wire uks_pkg::shift_t           shift,
  input  wire logic [CNT_W-1:0]          fill,
  input  wire logic [uks_pkg::KEY_W-1:0]   up_key,
  input  wire logic [uks_pkg::VALUE_W-1:0] up_value,
  input  wire logic [uks_pkg::KEY_W-1:0]   down_key,
  input  wire logic [uks_pkg::VALUE_W-1:0] down_value,
  input  wire logic [uks_pkg::KEY_W-1:0]   cmp_key,
  output logic [uks_pkg::KEY_W-1:0]        cell_key,
  output logic [uks_pkg::VALUE_W-1:0]      cell_value,
  output logic                           match
);
  import uks_pkg::*;

  logic occupied;

  // Slot INDEX holds a live entry when more than INDEX entries are stacked.
  assign occupied = (fill > CNT_W'(INDEX));
  assign match    = occupied && (cell_key == cmp_key);

  always_ff @(posedge clk) begin
    if (shift.push) begin
      cell_key   <= up_key;
      cell_value <= up_value;
    end else if (shift.pop) begin
      cell_key   <= down_key;
      cell_value <= down_value;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/unique_key_stack.sv -----
`default_nettype none
// Last-in-first-out stack of up to DEPTH key/value pairs that never holds
// two entries with the same key. Each input word is a push, pop or peek; each
// request yields exactly one result word carrying a status (ok, duplicate
// key, underflow, full), the popped or peeked pair (zero otherwise), the
// entry count after the request and an empty flag. A push whose key is
// already present reports duplicate even when the stack is also full, and
// the unused opcode leaves the stack alone and reports ok. The entries live
// in a row of cells with the top of stack in cell 0; every cell compares its
// key against the request key in the same cycle and the whole row shifts by
// one place on a push or pop. The block sustains one request per cycle: the
// single output register is the only limit, and a new word is taken whenever
// that register is empty or its word is being taken in the same cycle. The
// entry count is reported in five bits, enough for the default depth of 16.
module unique_key_stack #(
  parameter int DEPTH = uks_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [uks_pkg::OPCODE_W-1:0]  opcode,
  input  wire logic signed [uks_pkg::KEY_W-1:0]   entry_key,
  input  wire logic signed [uks_pkg::VALUE_W-1:0] entry_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [uks_pkg::STATUS_W-1:0]       status,
  output logic signed [uks_pkg::KEY_W-1:0]   top_key,
  output logic signed [uks_pkg::VALUE_W-1:0] top_value,
  output logic [uks_pkg::COUNT_W-1:0]        entry_count,
  output logic                               is_empty
);
  import uks_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Cell chain data.
  logic [KEY_W-1:0]   cell_key   [DEPTH];
  logic [VALUE_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]   match;
  shift_t             shift;

  // Control state.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Request decode.
  logic                accept;
  logic                dup;
  logic                full;
  logic                empty;
  logic [STATUS_W-1:0] status_next;
  logic                give_top;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign dup   = |match;
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    shift       = '0;
    status_next = ST_OK;
    give_top    = 1'b0;
    count_next  = count;
    unique case (opcode)
      OP_PUSH: begin
        if (dup) begin
          status_next = ST_DUP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          shift.push = accept;
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_next = ST_UNDER;
        end else begin
          shift.pop  = accept;
          give_top   = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status_next = ST_UNDER;
        end else begin
          give_top = 1'b1;
        end
      end
      default: begin
        // Unused opcode: nothing moves, status stays ok.
      end
    endcase
  end

  // The reported count is the low bits of the post-request count.
  assign count_wide = {{COUNT_W{1'b0}}, count_next};

  // The row of cells. Cell 0 takes the pushed pair from the request; the
  // deepest cell takes zeros on a pop, which are never read as live data.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0]   up_key;
    logic [VALUE_W-1:0] up_value;
    logic [KEY_W-1:0]   down_key;
    logic [VALUE_W-1:0] down_value;

    if (i == 0) begin : g_top
      assign up_key   = entry_key;
      assign up_value = entry_value;
    end else begin : g_mid
      assign up_key   = cell_key[i-1];
      assign up_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign down_key   = '0;
      assign down_value = '0;
    end else begin : g_inner
      assign down_key   = cell_key[i+1];
      assign down_value = cell_value[i+1];
    end

    uks_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .shift      (shift),
      .fill       (count),
      .up_key     (up_key),
      .up_value   (up_value),
      .down_key   (down_key),
      .down_value (down_value),
      .cmp_key    (entry_key),
      .cell_key   (cell_key[i]),
      .cell_value (cell_value[i]),
      .match      (match[i])
    );
  end

  // Fill count and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word; loaded only when a request is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      top_key     <= give_top ? cell_key[0] : '0;
      top_value   <= give_top ? cell_value[0] : '0;
      entry_count <= count_wide[COUNT_W-1:0];
      is_empty    <= (count_next == '0);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/uks_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the stack's result channel and input handshake.
module uks_checker #(
  parameter int DEPTH = uks_pkg::DEPTH_DEFAULT
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [uks_pkg::OPCODE_W-1:0]  opcode,
  input wire logic [uks_pkg::KEY_W-1:0]     entry_key,
  input wire logic [uks_pkg::VALUE_W-1:0]   entry_value,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [uks_pkg::STATUS_W-1:0]  status,
  input wire logic [uks_pkg::KEY_W-1:0]     top_key,
  input wire logic [uks_pkg::VALUE_W-1:0]   top_value,
  input wire logic [uks_pkg::COUNT_W-1:0]   entry_count,
  input wire logic                          is_empty
);
  import uks_pkg::*;

  logic unused_ok;
  assign unused_ok = in_valid ^ (|opcode) ^ (|entry_key) ^ (|entry_value) ^ (DEPTH > 0);

  // A held result word keeps its payload until it is taken.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(top_key) && $stable(entry_count))

  // The empty flag agrees with the count.
  `ASSERT_SAME(a_empty_count, clk, rst, out_valid, is_empty == (entry_count == '0))

  // Underflow only occurs on an empty stack and returns no pair.
  `ASSERT_SAME(a_under, clk, rst, out_valid && status == ST_UNDER, is_empty && top_key == '0 && top_value == '0)

  // A refused duplicate push needs a non-empty stack and returns no pair.
  `ASSERT_SAME(a_dup, clk, rst, out_valid && status == ST_DUP, !is_empty && top_key == '0 && top_value == '0)

  // No new word is taken while a result word is stalled.
  `ASSERT_SAME(a_ready, clk, rst, out_valid && !out_ready, !in_ready)

endmodule

bind unique_key_stack uks_checker #(.DEPTH(DEPTH)) u_uks_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .opcode      (opcode),
  .entry_key   (entry_key),
  .entry_value (entry_value),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .top_key     (top_key),
  .top_value   (top_value),
  .entry_count (entry_count),
  .is_empty    (is_empty)
);
`default_nettype wire
